[rtl/core/rlc_pkg.sv]
package rlc_pkg;

  // Slots in one radio frame; slot 0 and the half-frame slot carry sync.
  localparam int unsigned SlotsPerFrame = 20;
  localparam int unsigned SyncSlotB     = SlotsPerFrame / 2;

  localparam int unsigned BwW   = 7;
  localparam int unsigned SymW  = 3;
  localparam int unsigned ModeW = 3;
  localparam int unsigned CfiW  = 2;
  localparam int unsigned SlotW = 5;
  localparam int unsigned BlkW  = 7;
  localparam int unsigned CntW  = 7;
  localparam int unsigned CfgDataW = 7;

  // Reset values of the configuration registers.
  localparam logic [BwW-1:0]  BwReset  = 7'd100;
  localparam logic [SymW-1:0] SymReset = 3'd7;

  // Configuration register indexes.
  typedef enum logic {
    REG_BANDWIDTH = 1'b0,
    REG_SYMBOLS   = 1'b1
  } cfg_reg_e;

  // Channel modes.
  typedef enum logic [ModeW-1:0] {
    MODE_PDSCH = 3'd0,
    MODE_PBCH  = 3'd1,
    MODE_SYNC  = 3'd2,
    MODE_CTRL  = 3'd3,
    MODE_PMCH  = 3'd4
  } mode_e;

  typedef struct packed {
    logic [BwW-1:0]  bandwidth_blocks;
    logic [SymW-1:0] symbols_per_slot;
  } cfg_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [CfiW-1:0]  cfi;
    logic [SlotW-1:0] slot;
    logic [BlkW-1:0]  block;
  } query_t;

  typedef struct packed {
    logic [CntW-1:0] re_count;
    logic [SymW-1:0] first_symbol;
    logic [SymW-1:0] last_symbol;
    logic            invalid;
  } result_t;

  typedef struct packed {
    logic           ok;
    logic [BlkW-1:0] lo;
    logic [BlkW-1:0] n;
  } central_t;

  // Central block range for each supported bandwidth.
  function automatic central_t central_range(logic [BwW-1:0] bw);
    central_t r;
    r = '{ok: 1'b1, lo: 7'd0, n: 7'd0};
    case (bw)
      7'd6:    begin r.lo = 7'd0;  r.n = 7'd6; end
      7'd7:    begin r.lo = 7'd0;  r.n = 7'd7; end
      7'd15:   begin r.lo = 7'd4;  r.n = 7'd7; end
      7'd25:   begin r.lo = 7'd9;  r.n = 7'd7; end
      7'd50:   begin r.lo = 7'd22; r.n = 7'd6; end
      7'd75:   begin r.lo = 7'd34; r.n = 7'd7; end
      7'd100:  begin r.lo = 7'd47; r.n = 7'd6; end
      default: begin r.ok = 1'b0;  r.lo = 7'd0; r.n = 7'd0; end
    endcase
    return r;
  endfunction

endpackage

[rtl/core/rlc_cfg.sv]
module rlc_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [rlc_pkg::CfgDataW-1:0] cfg_data_i,
  output rlc_pkg::cfg_t                cfg_o
);

  rlc_pkg::cfg_t cfg_q, cfg_d;

  // Register writes select a field by index; other fields keep their value.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        rlc_pkg::REG_BANDWIDTH: cfg_d.bandwidth_blocks = cfg_data_i[rlc_pkg::BwW-1:0];
        rlc_pkg::REG_SYMBOLS:   cfg_d.symbols_per_slot = cfg_data_i[rlc_pkg::SymW-1:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bandwidth_blocks <= rlc_pkg::BwReset;
      cfg_q.symbols_per_slot <= rlc_pkg::SymReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/rlc_calc.sv]
module rlc_calc (
  input  rlc_pkg::cfg_t    cfg_i,
  input  rlc_pkg::query_t  query_i,
  output rlc_pkg::result_t result_o
);

  localparam int unsigned AW = 10;

  rlc_pkg::central_t   cr;
  logic                bad;
  logic                central;
  logic                edge_blk;
  logic                sync_slot;
  logic                even_slot;
  logic [rlc_pkg::BlkW:0] hi_excl;
  logic signed [AW-1:0] s;
  logic signed [AW-1:0] cfi;
  logic signed [AW-1:0] ctl;
  logic signed [AW-1:0] res;
  logic signed [AW-1:0] first;
  logic signed [AW-1:0] last;
  logic [1:0]           cfi_max;

  // Validity checks and block classification.
  always_comb begin
    cr        = rlc_pkg::central_range(cfg_i.bandwidth_blocks);
    hi_excl   = {1'b0, cr.lo} + {1'b0, cr.n};
    central   = (query_i.block >= cr.lo) && ({1'b0, query_i.block} < hi_excl);
    edge_blk  = central && cr.n[0] &&
                ((query_i.block == cr.lo) ||
                 ({1'b0, query_i.block} == hi_excl - 8'd1));
    sync_slot = (query_i.slot == 5'd0) ||
                (query_i.slot == rlc_pkg::SlotW'(rlc_pkg::SyncSlotB));
    even_slot = !query_i.slot[0];
    cfi_max   = (query_i.mode == rlc_pkg::MODE_PMCH) ? 2'd2 : 2'd3;
    bad       = !cr.ok ||
                (query_i.block >= cfg_i.bandwidth_blocks) ||
                (query_i.slot >= rlc_pkg::SlotW'(rlc_pkg::SlotsPerFrame)) ||
                (query_i.mode > rlc_pkg::MODE_PMCH) ||
                (query_i.cfi == 2'd0) || (query_i.cfi > cfi_max);
  end

  // Region rules per channel, in signed arithmetic before saturation.
  always_comb begin
    s     = AW'(signed'({1'b0, cfg_i.symbols_per_slot}));
    cfi   = AW'(signed'({1'b0, query_i.cfi}));
    ctl   = cfi + ((cfg_i.bandwidth_blocks == 7'd6) ? 10'sd1 : 10'sd0);
    res   = '0;
    first = '0;
    last  = '0;
    case (query_i.mode)
      rlc_pkg::MODE_PDSCH: begin
        res   = s * 10'sd12 - 10'sd8;
        first = '0;
        last  = s;
        if (central && sync_slot) begin
          res  = (s - 10'sd2) * 10'sd12 - ((s == 10'sd7) ? 10'sd4 : 10'sd0);
          last = s - 10'sd2;
          if (edge_blk) begin
            res  = res + 10'sd12;
            last = s;
          end
        end else if (central && (query_i.slot == 5'd1)) begin
          res   = (s - 10'sd4) * 10'sd12 - 10'sd4;
          first = 10'sd4;
          last  = s;
          if (edge_blk) begin
            res   = res + 10'sd22;
            first = '0;
          end
        end
        if (even_slot) begin
          res   = res - (ctl * 10'sd12 - 10'sd4);
          first = cfi;
        end
      end
      rlc_pkg::MODE_PBCH: begin
        first = s;
        last  = s;
        if (central && !edge_blk && (query_i.slot == 5'd1)) begin
          res   = 10'sd40;
          first = '0;
          last  = 10'sd4;
        end
      end
      rlc_pkg::MODE_SYNC: begin
        first = s;
        last  = s;
        if (central && !edge_blk && sync_slot) begin
          res   = 10'sd24;
          first = s - 10'sd2;
        end
      end
      rlc_pkg::MODE_CTRL: begin
        if (!even_slot) begin
          first = s;
          last  = s;
        end else begin
          res  = ctl * 10'sd12 - 10'sd4;
          last = ctl;
        end
      end
      default: begin
        last = 10'sd6;
        if (!even_slot) begin
          res = 10'sd60;
        end else begin
          res   = (10'sd6 - cfi) * 10'sd12 - 10'sd6;
          first = cfi;
        end
      end
    endcase
  end

  // Saturate to the field ranges; unsupported queries give zero fields with invalid set.
  always_comb begin
    result_o = '0;
    if (bad) begin
      result_o.invalid = 1'b1;
    end else begin
      result_o.re_count     = (res < 0) ? '0 :
                              (res > 10'sd127) ? 7'd127 : res[rlc_pkg::CntW-1:0];
      result_o.first_symbol = (first < 0) ? '0 :
                              (first > 10'sd7) ? 3'd7 : first[rlc_pkg::SymW-1:0];
      result_o.last_symbol  = (last < 0) ? '0 :
                              (last > 10'sd7) ? 3'd7 : last[rlc_pkg::SymW-1:0];
    end
  end

endmodule

[rtl/core/lte_downlink_re_count.sv]
// Downlink resource element count lookup, one query per beat.
//
// Input channel: a query (mode_i, cfi_i, slot_i, block_i) is taken at each
// rising clock edge with start_i high and busy_o low. busy_o stays low, so
// a query can be issued in every cycle.
// Result channel: valid_o is high for one cycle with re_count_o,
// first_symbol_o, last_symbol_o and invalid_o. The receiver cannot stall;
// each result is taken in the cycle that it is shown.
// Order: a query taken at an edge is registered in the input register, the
// lookup logic runs on it in the following cycle, and valid_o rises as the
// result register loads. Throughput is one query per cycle, set by the
// single input register to result register stage.
// Configuration: cfg_we_i writes cfg_data_i to the register named by
// cfg_idx_i (0 bandwidth in blocks, 1 symbols per slot); the user must write
// only while no query is in flight, as the block does not enforce it.
// Reset: the bandwidth returns to 100 blocks, symbols per slot to 7, and
// any queries in flight are dropped.
module lte_downlink_re_count (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [rlc_pkg::ModeW-1:0]    mode_i,
  input  logic [rlc_pkg::CfiW-1:0]     cfi_i,
  input  logic [rlc_pkg::SlotW-1:0]    slot_i,
  input  logic [rlc_pkg::BlkW-1:0]     block_i,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [rlc_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                         valid_o,
  output logic [rlc_pkg::CntW-1:0]     re_count_o,
  output logic [rlc_pkg::SymW-1:0]     first_symbol_o,
  output logic [rlc_pkg::SymW-1:0]     last_symbol_o,
  output logic                         invalid_o
);

  rlc_pkg::cfg_t    cfg;
  rlc_pkg::query_t  query_q;
  rlc_pkg::result_t result_d, result_q;
  logic             in_vld_q;
  logic             out_vld_q;

  assign busy_o = 1'b0;

  rlc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Valid bits of the input and result stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start_i && !busy_o;
      out_vld_q <= in_vld_q;
    end
  end

  // Input register for the query beat.
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      query_q <= '{mode: mode_i, cfi: cfi_i, slot: slot_i, block: block_i};
    end
  end

  rlc_calc u_calc (
    .cfg_i    (cfg),
    .query_i  (query_q),
    .result_o (result_d)
  );

  // Result register.
  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      result_q <= result_d;
    end
  end

  assign valid_o        = out_vld_q;
  assign re_count_o     = result_q.re_count;
  assign first_symbol_o = result_q.first_symbol;
  assign last_symbol_o  = result_q.last_symbol;
  assign invalid_o      = result_q.invalid;

`ifndef SYNTHESIS
  // Each accepted query yields a result through the input and result registers.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 valid_o)
    else $error("query accepted without a result two cycles later");

  // A result only appears for a query held in the input stage.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(in_vld_q))
    else $error("result beat without a query in the input stage");

  // Unsupported queries report all zero fields.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && invalid_o) |->
      (re_count_o == '0 && first_symbol_o == '0 && last_symbol_o == '0))
    else $error("invalid result carries nonzero fields");

  // No channel region holds more than a full block of resource elements.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (re_count_o <= 7'd84))
    else $error("resource element count above a full block");
`endif

endmodule

[dv/re_count_tb_pkg.sv]
`timescale 1ns / 1ps

package re_count_tb_pkg;
  import rlc_pkg::*;

  // Tracks the two configuration registers, predicts the lookup for each
  // accepted query beat and checks the result beats in order.
  class re_count_scoreboard;
    logic [BwW-1:0]  bandwidth;
    logic [SymW-1:0] symbols;
    result_t         expected_re[$];
    int unsigned     errors;

    function new();
      bandwidth = BwReset;
      symbols   = SymReset;
      errors    = 0;
    endfunction

    function void set_bandwidth(logic [CfgDataW-1:0] data);
      bandwidth = data[BwW-1:0];
    endfunction

    function void set_symbols(logic [CfgDataW-1:0] data);
      symbols = data[SymW-1:0];
    endfunction

    function int unsigned outstanding();
      return expected_re.size();
    endfunction

    // Negative values become zero, large ones stop at the field maximum.
    function int unsigned sat(int v, int hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
    endfunction

    // Resource element count and symbol span for one query.
    function result_t lookup_re_count(query_t q);
      result_t r;
      int      lo;
      int      n;
      int      s;
      int      cfi;
      int      blk;
      int      extra;
      int      res;
      int      first;
      int      last;
      bit      bad;
      bit      central;
      bit      rim;
      bit      sync_slot;
      r     = '0;
      s     = int'(symbols);
      cfi   = int'(q.cfi);
      blk   = int'(q.block);
      extra = (bandwidth == 7'd6) ? 1 : 0;
      bad   = 1'b0;

      // Central blocks that carry sync and broadcast for each bandwidth.
      case (bandwidth)
        7'd6: begin
          lo = 0;  n = 6;
        end
        7'd7: begin
          lo = 0;  n = 7;
        end
        7'd15: begin
          lo = 4;  n = 7;
        end
        7'd25: begin
          lo = 9;  n = 7;
        end
        7'd50: begin
          lo = 22; n = 6;
        end
        7'd75: begin
          lo = 34; n = 7;
        end
        7'd100: begin
          lo = 47; n = 6;
        end
        default: begin
          lo = 0;  n = 0; bad = 1'b1;
        end
      endcase

      if (blk >= int'(bandwidth)) bad = 1'b1;
      if (q.slot >= SlotsPerFrame) bad = 1'b1;
      if (q.mode > MODE_PMCH) bad = 1'b1;
      if (cfi < 1 || cfi > ((q.mode == MODE_PMCH) ? 2 : 3)) bad = 1'b1;
      if (bad) begin
        r.invalid = 1'b1;
        return r;
      end

      central   = (blk >= lo) && (blk < lo + n);
      rim       = central && (n % 2 == 1) && (blk == lo || blk == lo + n - 1);
      sync_slot = (q.slot == 0) || (q.slot == SyncSlotB);
      res       = 0;
      first     = s;
      last      = s;

      case (q.mode)
        MODE_PDSCH: begin
          res   = 12 * s - 8;
          first = 0;
          if (central && sync_slot) begin
            res  = 12 * (s - 2) - ((s == 7) ? 4 : 0);
            last = s - 2;
            if (rim) begin
              res  = res + 12;
              last = s;
            end
          end else if (central && q.slot == 1) begin
            res   = 12 * (s - 4) - 4;
            first = 4;
            if (rim) begin
              res   = res + 22;
              first = 0;
            end
          end
          // The control region takes the head of every even slot.
          if (!q.slot[0]) begin
            res   = res - (12 * (cfi + extra) - 4);
            first = cfi;
          end
        end
        MODE_PBCH: begin
          if (central && !rim && q.slot == 1) begin
            res = 40; first = 0; last = 4;
          end
        end
        MODE_SYNC: begin
          if (central && !rim && sync_slot) begin
            res = 24; first = s - 2;
          end
        end
        MODE_CTRL: begin
          if (!q.slot[0]) begin
            res = 12 * (cfi + extra) - 4; first = 0; last = cfi + extra;
          end
        end
        default: begin
          // Multicast always uses the extended prefix grid.
          last = 6;
          if (q.slot[0]) begin
            res = 60; first = 0;
          end else begin
            res = (6 - cfi) * 12 - 6; first = cfi;
          end
        end
      endcase

      r.re_count     = CntW'(sat(res, 127));
      r.first_symbol = SymW'(sat(first, 7));
      r.last_symbol  = SymW'(sat(last, 7));
      return r;
    endfunction

    function void note_query(query_t q);
      expected_re = {expected_re, lookup_re_count(q)};
    endfunction

    function void flag_error(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_re.size() == 0) begin
        flag_error($sformatf("unexpected result: count %0d first %0d last %0d invalid %0b",
                             got.re_count, got.first_symbol, got.last_symbol, got.invalid));
        return;
      end
      want = expected_re.pop_front();
      if (got.re_count !== want.re_count || got.first_symbol !== want.first_symbol ||
          got.last_symbol !== want.last_symbol || got.invalid !== want.invalid) begin
        flag_error($sformatf({"result mismatch: expected count %0d first %0d last %0d ",
                              "invalid %0b, got count %0d first %0d last %0d invalid %0b"},
                             want.re_count, want.first_symbol, want.last_symbol, want.invalid,
                             got.re_count, got.first_symbol, got.last_symbol, got.invalid));
      end
    endfunction
  endclass

endpackage

[dv/tb_lte_downlink_re_count.sv]
`timescale 1ns / 1ps

module tb_lte_downlink_re_count;
  import rlc_pkg::*;
  import re_count_tb_pkg::*;

  localparam int unsigned ItemsPerPhase = 136;
  localparam int unsigned Phases        = 14;
  localparam int unsigned StallLimit    = 1000;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                start_i    = 1'b0;
  logic [ModeW-1:0]    mode_i     = '0;
  logic [CfiW-1:0]     cfi_i      = '0;
  logic [SlotW-1:0]    slot_i     = '0;
  logic [BlkW-1:0]     block_i    = '0;
  logic                cfg_we_i   = 1'b0;
  logic                cfg_idx_i  = 1'b0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                busy_o;
  logic                valid_o;
  logic [CntW-1:0]     re_count_o;
  logic [SymW-1:0]     first_symbol_o;
  logic [SymW-1:0]     last_symbol_o;
  logic                invalid_o;

  re_count_scoreboard sb = new();
  int unsigned        cur_bw = BwReset;
  int unsigned        quiet_cycles = 0;

  // Settings of the random phases; the last two are drawn at random.
  int unsigned bw_plan[12]  = '{100, 6, 7, 15, 25, 50, 75, 100, 0, 127, 75, 6};
  int unsigned sym_plan[12] = '{6, 7, 6, 7, 6, 7, 6, 0, 7, 5, 3, 1};

  lte_downlink_re_count dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .mode_i         (mode_i),
    .cfi_i          (cfi_i),
    .slot_i         (slot_i),
    .block_i        (block_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .valid_o        (valid_o),
    .re_count_o     (re_count_o),
    .first_symbol_o (first_symbol_o),
    .last_symbol_o  (last_symbol_o),
    .invalid_o      (invalid_o)
  );

  always #6 clk_i = ~clk_i;

  // Sample both channels at each edge; results are checked before the
  // query beat of the same edge is noted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) begin
        sb.check_result('{re_count: re_count_o, first_symbol: first_symbol_o,
                          last_symbol: last_symbol_o, invalid: invalid_o});
      end
      if (start_i && !busy_o) begin
        sb.note_query('{mode: mode_i, cfi: cfi_i, slot: slot_i, block: block_i});
      end
    end
  end

  // End the run when neither channel has moved a beat for too long.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Present one query and hold it until the block takes it.
  task automatic send_query(logic [ModeW-1:0] mode, logic [CfiW-1:0] cfi,
                            logic [SlotW-1:0] slot, logic [BlkW-1:0] blk);
    start_i <= 1'b1;
    mode_i  <= mode;
    cfi_i   <= cfi;
    slot_i  <= slot;
    block_i <= blk;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic pause(int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Let every query in flight finish, then write both registers.
  task automatic reconfigure(int unsigned bw, int unsigned sym);
    start_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_BANDWIDTH;
    cfg_data_i <= CfgDataW'(bw);
    @(posedge clk_i);
    sb.set_bandwidth(CfgDataW'(bw));
    cfg_idx_i  <= REG_SYMBOLS;
    // Bits above the register width are ignored by the block.
    cfg_data_i <= {4'($urandom_range(0, 15)), SymW'(sym)};
    @(posedge clk_i);
    sb.set_symbols(CfgDataW'(sym));
    cfg_we_i <= 1'b0;
    cur_bw = bw;
  endtask

  // Mostly well-formed queries aimed at the central blocks and the special
  // slots, with a share of raw noise across every field.
  task automatic send_random_query();
    logic [ModeW-1:0] mode;
    logic [CfiW-1:0]  cfi;
    logic [SlotW-1:0] slot;
    logic [BlkW-1:0]  blk;
    int unsigned      mid;
    int unsigned      lo_w;
    int unsigned      hi_w;
    int unsigned      special[4];
    special = '{0, 1, SyncSlotB, SyncSlotB + 1};
    if ($urandom_range(0, 99) < 15) begin
      mode = ModeW'($urandom_range(0, 7));
      cfi  = CfiW'($urandom_range(0, 3));
      slot = SlotW'($urandom_range(0, 31));
      blk  = BlkW'($urandom_range(0, 127));
    end else begin
      mode = ModeW'($urandom_range(0, 4));
      cfi  = CfiW'($urandom_range(1, (mode == MODE_PMCH) ? 2 : 3));
      if ($urandom_range(0, 9) < 4) slot = SlotW'(special[$urandom_range(0, 3)]);
      else slot = SlotW'($urandom_range(0, SlotsPerFrame - 1));
      if (cur_bw == 0) begin
        blk = BlkW'($urandom_range(0, 127));
      end else if ($urandom_range(0, 1) == 0) begin
        mid  = cur_bw / 2;
        lo_w = (mid >= 4) ? mid - 4 : 0;
        hi_w = (mid + 4 < cur_bw) ? mid + 4 : cur_bw - 1;
        blk  = BlkW'($urandom_range(lo_w, hi_w));
      end else begin
        blk = BlkW'($urandom_range(0, cur_bw - 1));
      end
    end
    send_query(mode, cfi, slot, blk);
  endtask

  initial begin
    int unsigned bw;
    int unsigned sym;
    int unsigned items;
    int unsigned burst;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed queries at the reset setting of 100 blocks, 7 symbols.
    send_query(MODE_PDSCH, 2'd1, 5'd3, 7'd0);
    send_query(MODE_PDSCH, 2'd3, 5'd2, 7'd99);
    send_query(MODE_PDSCH, 2'd2, 5'd0, 7'd47);
    send_query(MODE_PDSCH, 2'd1, SlotW'(SyncSlotB), 7'd52);
    send_query(MODE_PDSCH, 2'd1, 5'd1, 7'd50);
    send_query(MODE_PBCH, 2'd1, 5'd1, 7'd48);
    send_query(MODE_PBCH, 2'd2, 5'd0, 7'd48);
    send_query(MODE_SYNC, 2'd3, 5'd0, 7'd50);
    send_query(MODE_SYNC, 2'd1, 5'd5, 7'd50);
    send_query(MODE_CTRL, 2'd3, 5'd0, 7'd10);
    send_query(MODE_CTRL, 2'd2, 5'd19, 7'd10);
    send_query(MODE_PMCH, 2'd2, 5'd0, 7'd0);
    send_query(MODE_PMCH, 2'd1, 5'd3, 7'd0);
    // Unsupported queries: cfi out of range, block past the bandwidth,
    // slot past the frame and modes above the last channel.
    send_query(MODE_PMCH, 2'd3, 5'd0, 7'd0);
    send_query(MODE_PDSCH, 2'd0, 5'd4, 7'd3);
    send_query(MODE_PDSCH, 2'd1, 5'd4, 7'd100);
    send_query(3'd7, 2'd3, 5'd31, 7'd127);
    send_query(3'd5, 2'd1, 5'd20, 7'd20);

    // Odd bandwidth: the two rim blocks of the central range.
    reconfigure(75, 7);
    send_query(MODE_PDSCH, 2'd1, 5'd0, 7'd34);
    send_query(MODE_PDSCH, 2'd2, 5'd1, 7'd40);
    send_query(MODE_PBCH, 2'd1, 5'd1, 7'd34);
    send_query(MODE_SYNC, 2'd1, SlotW'(SyncSlotB), 7'd40);

    // Narrowest bandwidth widens the control region by one symbol.
    reconfigure(6, 6);
    send_query(MODE_CTRL, 2'd3, 5'd0, 7'd5);
    send_query(MODE_PDSCH, 2'd3, 5'd0, 7'd0);
    send_query(MODE_PDSCH, 2'd1, 5'd0, 7'd6);

    // Random phases, each sent in bursts with random gaps.
    for (int p = 0; p < Phases; p++) begin
      bw  = (p < 12) ? bw_plan[p] : $urandom_range(0, 127);
      sym = (p < 12) ? sym_plan[p] : $urandom_range(0, 7);
      reconfigure(bw, sym);
      items = 0;
      while (items < ItemsPerPhase) begin
        burst = $urandom_range(1, 40);
        for (int i = 0; i < burst && items < ItemsPerPhase; i++) begin
          send_random_query();
          items++;
        end
        if ($urandom_range(0, 9) >= 3) pause($urandom_range(1, 8));
      end
    end

    // Drain and let the pipeline settle before the verdict.
    start_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
